### rtl/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg
// Shared codes and types of the chained hash table engine: command and status
// codes, the controller states and the command and status groups.
// ----------------------------------------------------------------------------
package chte_pkg;

	// Command codes of an input word.
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_FIND   = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_FETCH  = 3'd3;
	localparam logic [2:0] CMD_PURGE  = 3'd4;

	// Status codes of a result word.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	// Fixed field widths of the channels and the configuration register.
	localparam int CMD_W      = 3;
	localparam int POS_W      = 10;
	localparam int STATUS_W   = 2;
	localparam int FOUND_W    = 32;
	localparam int BUCKET_W   = 8;
	localparam int LIVE_W     = 11;
	localparam int CFG_W      = 9;

	// Hash bits retired by the remainder unit in each cycle.
	localparam int RADIX_BITS = 4;

	// Operations that the controller asks of the datapath.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_INS_READ,
		OP_INS_WRITE,
		OP_HEAD_READ,
		OP_SCAN_HEAD,
		OP_LOAD,
		OP_NODE_READ,
		OP_FIND_CHECK,
		OP_NOT_FOUND,
		OP_SCAN_NEXT,
		OP_FETCH_CHECK,
		OP_FETCH_MISS,
		OP_PURGE_CHECK,
		OP_PURGE_FIX,
		OP_FINISH
	} chte_op_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_INS_RD,
		S_INS_WR,
		S_FR_HEAD,
		S_FR_LOAD,
		S_FR_WALK,
		S_FR_CHECK,
		S_SC_HEAD,
		S_SC_LOAD,
		S_SC_WALK,
		S_FT_CHECK,
		S_PG_CHECK,
		S_PG_FIX,
		S_FIN
	} chte_state_t;

	// Controller to datapath.
	typedef struct packed {
		chte_op_t op;
		logic     in_ready;
	} chte_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic accept;
		logic clear_last;
		logic div_done;
		logic is_insert;
		logic is_findrem;
		logic is_fetch;
		logic is_purge;
		logic cur_end;
		logic match;
		logic fetch_hit;
		logic dead;
		logic prev_nil;
		logic scan_end;
		logic out_free;
	} chte_status_t;

endpackage

### rtl/chte_in_if.sv
// ----------------------------------------------------------------------------
// chte_in_if
// Command channel: valid, ready and the fields of one command word.
// ----------------------------------------------------------------------------
interface chte_in_if #(
	parameter int HASH_BITS  = 32,
	parameter int VALUE_BITS = 32
);
	logic                             valid;
	logic                             ready;
	logic [chte_pkg::CMD_W-1:0]       cmd;
	logic [HASH_BITS-1:0]             hash_value;
	logic [VALUE_BITS-1:0]            item_value;
	logic [chte_pkg::POS_W-1:0]       position;

	modport source (output valid, cmd, hash_value, item_value, position, input ready);
	modport sink (input valid, cmd, hash_value, item_value, position, output ready);
endinterface

### rtl/chte_out_if.sv
// ----------------------------------------------------------------------------
// chte_out_if
// Result channel: valid, ready and the fields of one result word.
// ----------------------------------------------------------------------------
interface chte_out_if;
	logic                              valid;
	logic                              ready;
	logic [chte_pkg::STATUS_W-1:0]     status;
	logic [chte_pkg::FOUND_W-1:0]      found_value;
	logic [chte_pkg::BUCKET_W-1:0]     bucket;
	logic [chte_pkg::LIVE_W-1:0]       live_count;

	modport source (output valid, status, found_value, bucket, live_count, input ready);
	modport sink (input valid, status, found_value, bucket, live_count, output ready);
endinterface

### rtl/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Hash table with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// Usage: command words arrive on the request channel (cmd, hash_value,
// item_value, position) and each produces exactly one result word on the
// response channel (status, found_value, bucket, live_count). The bucket
// count register is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce it.
// One command is worked on at a time. Every command passes a capture step,
// the remainder unit and a final step that loads the result register. In
// between, insert reads and then writes; find and remove read the bucket
// head, load it and read and check each chain node visited, with a
// not-found step when nothing matches; fetch and purge read up to
// NUM_BUCKETS heads, walk each chain and close the scan, a fetch stopping
// at its hit, and a purge adds a fix step per dead node unlinked behind a
// live one. After reset a clearing pass sets every bucket head to empty;
// request.ready stays low until it ends. The result register lets the
// next word be taken while a result waits; a stalled response holds its
// word, and a finished command waits for it to be taken.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_unit #(
	parameter int NUM_BUCKETS = 256,
	parameter int NUM_NODES   = 1024,
	parameter int VALUE_BITS  = 32,
	parameter int HASH_BITS   = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	chte_in_if.sink                    request,
	chte_out_if.source                 response,
	input  logic                       cfg_wr_en,
	input  logic [chte_pkg::CFG_W-1:0] cfg_wr_data
);
	chte_pkg::chte_cmd_t    cmd;
	chte_pkg::chte_status_t st;

	// Controller.
	chte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// Datapath.
	chte_dp #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.NUM_NODES   (NUM_NODES),
		.VALUE_BITS  (VALUE_BITS),
		.HASH_BITS   (HASH_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request),
		.response    (response),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.st          (st)
	);

`ifndef NO_ASSERTIONS
	// An accepted word closes the request side until its result is built.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> !request.ready)
		else $error("request accepted while a command is in progress");

	// A failed command never reports a bucket.
	a_bucket_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid && response.status != chte_pkg::ST_OK |-> response.bucket == '0)
		else $error("bucket reported on a failed command");

	// The live count cannot exceed the node pool.
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid |-> 32'(response.live_count) <= NUM_NODES)
		else $error("live count above pool size");
`endif
endmodule

### rtl/chte_mod.sv
// ----------------------------------------------------------------------------
// chte_mod
// Iterative remainder unit: hash modulo bucket count, a few bits per cycle
// by restoring subtraction.
// ----------------------------------------------------------------------------
module chte_mod #(
	parameter int HASH_BITS   = 32,
	parameter int NUM_BUCKETS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [HASH_BITS-1:0]                dividend,
	input  logic [$clog2(NUM_BUCKETS+1)-1:0]    divisor,
	output logic                                done,
	output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] rem
);
	localparam int BIW   = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
	localparam int BCW   = $clog2(NUM_BUCKETS + 1);
	localparam int ITERS = (HASH_BITS + chte_pkg::RADIX_BITS - 1) / chte_pkg::RADIX_BITS;
	localparam int PAD   = ITERS * chte_pkg::RADIX_BITS;
	localparam int CW    = $clog2(ITERS + 1);

	logic [PAD-1:0] sh_q;
	logic [BIW-1:0] rem_q;
	logic [BCW-1:0] div_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [BIW-1:0] rem_nx;

	// One radix step: shift in RADIX_BITS bits, subtracting the divisor once after each bit if it fits.
	always_comb begin
		logic [BIW:0] t;
		rem_nx = rem_q;
		for (int k = 0; k < chte_pkg::RADIX_BITS; k++) begin
			t = {rem_nx, sh_q[PAD-1-k]};
			if (t >= (BIW+1)'(div_q)) begin
				t = t - (BIW+1)'(div_q);
			end
			rem_nx = t[BIW-1:0];
		end
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ITERS);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CW'(1);
			done_q <= cnt_q == CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifter and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= PAD'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			sh_q  <= sh_q << chte_pkg::RADIX_BITS;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

### rtl/chte_dp.sv
// ----------------------------------------------------------------------------
// chte_dp
// Datapath of the hash table engine: bucket heads and node memories, walk
// registers, free list, counters and the result register.
// ----------------------------------------------------------------------------
module chte_dp #(
	parameter int NUM_BUCKETS = 256,
	parameter int NUM_NODES   = 1024,
	parameter int VALUE_BITS  = 32,
	parameter int HASH_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	chte_in_if.sink                       request,
	chte_out_if.source                    response,
	input  logic                          cfg_wr_en,
	input  logic [chte_pkg::CFG_W-1:0]    cfg_wr_data,
	input  chte_pkg::chte_cmd_t           cmd,
	output chte_pkg::chte_status_t        st
);
	localparam int BIW = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
	localparam int BCW = $clog2(NUM_BUCKETS + 1);
	localparam int NW  = $clog2(NUM_NODES + 1);
	localparam int NIW = $clog2(NUM_NODES);
	localparam logic [NW-1:0] NIL = NW'(NUM_NODES);

	// Memories.
	logic [NW-1:0]         heads_mem [NUM_BUCKETS];
	logic [VALUE_BITS-1:0] val_mem   [NUM_NODES];
	logic [NW-1:0]         link_mem  [NUM_NODES];
	logic                  dead_mem  [NUM_NODES];

	// Control registers.
	logic [BCW-1:0] bc_q;
	logic [BIW-1:0] clr_q;
	logic [NW-1:0]  free_head_q;
	logic [NW-1:0]  top_q;
	logic [NW-1:0]  live_q;
	logic           out_valid_q;

	// Working registers.
	logic [chte_pkg::CMD_W-1:0] cmd_q;
	logic [VALUE_BITS-1:0]      val_q;
	logic [chte_pkg::POS_W-1:0] pos_q;
	logic [BCW-1:0]             r_q;
	logic [NW-1:0]              cur_q;
	logic [NW-1:0]              prev_q;
	logic [NW-1:0]              steps_q;
	logic [NW-1:0]              seen_q;
	logic [NW-1:0]              head_rd_q;
	logic [NW-1:0]              link_rd_q;
	logic [VALUE_BITS-1:0]      val_rd_q;
	logic                       dead_rd_q;
	logic [1:0]                 res_status_q;
	logic [VALUE_BITS-1:0]      res_fval_q;
	logic [BIW-1:0]             res_bucket_q;

	// Output register.
	logic [chte_pkg::STATUS_W-1:0] out_status_q;
	logic [chte_pkg::FOUND_W-1:0]  out_fval_q;
	logic [chte_pkg::BUCKET_W-1:0] out_bucket_q;
	logic [chte_pkg::LIVE_W-1:0]   out_live_q;

	// Remainder unit.
	logic           div_done;
	logic [BIW-1:0] b;

	chte_mod #(.HASH_BITS(HASH_BITS), .NUM_BUCKETS(NUM_BUCKETS)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == chte_pkg::OP_CAPTURE),
		.dividend (request.hash_value),
		.divisor  (bc_q),
		.done     (div_done),
		.rem      (b)
	);

	// Decoded conditions.
	logic from_free, full, match, fetch_hit, is_remove, is_purge;
	logic [NW-1:0] alloc_n;

	assign from_free = free_head_q != NIL;
	assign full      = !from_free && top_q == NIL;
	assign alloc_n   = from_free ? free_head_q : top_q;
	assign match     = !dead_rd_q && val_rd_q == val_q;
	assign fetch_hit = !dead_rd_q && 32'(seen_q) == 32'(pos_q);
	assign is_remove = cmd_q == chte_pkg::CMD_REMOVE;
	assign is_purge  = cmd_q == chte_pkg::CMD_PURGE;

	// Memory write and read controls.
	logic            heads_we, link_we, node_we, dead_we, dead_wd, head_re, node_re;
	logic [BIW-1:0]  heads_wa, heads_ra;
	logic [NW-1:0]   heads_wd, link_wd;
	logic [NIW-1:0]  link_wa, dead_wa, node_ra;

	always_comb begin
		heads_we = 1'b0;
		heads_wa = b;
		heads_wd = NIL;
		link_we  = 1'b0;
		link_wa  = cur_q[NIW-1:0];
		link_wd  = free_head_q;
		node_we  = 1'b0;
		dead_we  = 1'b0;
		dead_wa  = cur_q[NIW-1:0];
		dead_wd  = 1'b1;
		head_re  = 1'b0;
		heads_ra = b;
		node_re  = 1'b0;
		node_ra  = cur_q[NIW-1:0];
		case (cmd.op)
			chte_pkg::OP_CLEAR: begin
				heads_we = 1'b1;
				heads_wa = clr_q;
			end
			chte_pkg::OP_INS_READ: begin
				head_re = 1'b1;
				node_re = 1'b1;
				node_ra = free_head_q[NIW-1:0];
			end
			chte_pkg::OP_INS_WRITE: begin
				if (!full) begin
					heads_we = 1'b1;
					heads_wd = alloc_n;
					link_we  = 1'b1;
					link_wa  = alloc_n[NIW-1:0];
					link_wd  = head_rd_q;
					node_we  = 1'b1;
					dead_we  = 1'b1;
					dead_wa  = alloc_n[NIW-1:0];
					dead_wd  = 1'b0;
				end
			end
			chte_pkg::OP_HEAD_READ: head_re = 1'b1;
			chte_pkg::OP_SCAN_HEAD: begin
				head_re  = 1'b1;
				heads_ra = r_q[BIW-1:0];
			end
			chte_pkg::OP_NODE_READ: node_re = 1'b1;
			chte_pkg::OP_FIND_CHECK: dead_we = match && is_remove;
			chte_pkg::OP_PURGE_CHECK: begin
				if (dead_rd_q) begin
					link_we  = 1'b1;
					heads_we = prev_q == NIL;
					heads_wa = r_q[BIW-1:0];
					heads_wd = link_rd_q;
				end
			end
			chte_pkg::OP_PURGE_FIX: begin
				link_we = 1'b1;
				link_wa = prev_q[NIW-1:0];
				link_wd = cur_q;
			end
			default: ;
		endcase
	end

	// Memory ports with registered read data.
	always_ff @(posedge clk) begin
		if (heads_we) heads_mem[heads_wa] <= heads_wd;
		if (head_re) head_rd_q <= heads_mem[heads_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		if (node_we) val_mem[alloc_n[NIW-1:0]] <= val_q;
		if (dead_we) dead_mem[dead_wa] <= dead_wd;
		if (node_re) begin
			link_rd_q <= link_mem[node_ra];
			val_rd_q  <= val_mem[node_ra];
			dead_rd_q <= dead_mem[node_ra];
		end
	end

	// Table state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= BCW'(NUM_BUCKETS);
			clr_q       <= '0;
			free_head_q <= NIL;
			top_q       <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_wr_data == '0) begin
					bc_q <= BCW'(1);
				end else if (32'(cfg_wr_data) > NUM_BUCKETS) begin
					bc_q <= BCW'(NUM_BUCKETS);
				end else begin
					bc_q <= BCW'(cfg_wr_data);
				end
			end
			// A new result word takes precedence over the one being taken.
			if (cmd.op == chte_pkg::OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				chte_pkg::OP_CLEAR: clr_q <= clr_q + 1'b1;
				chte_pkg::OP_INS_WRITE: begin
					if (!full) begin
						live_q <= live_q + 1'b1;
						if (from_free) begin
							free_head_q <= link_rd_q;
						end else begin
							top_q <= top_q + 1'b1;
						end
					end
				end
				chte_pkg::OP_FIND_CHECK: begin
					if (match && is_remove && live_q != '0) live_q <= live_q - 1'b1;
				end
				chte_pkg::OP_PURGE_CHECK: begin
					if (dead_rd_q) free_head_q <= cur_q;
				end
				default: ;
			endcase
		end
	end

	// Walk registers and the pending result.
	always_ff @(posedge clk) begin
		case (cmd.op)
			chte_pkg::OP_CAPTURE: begin
				cmd_q        <= request.cmd;
				val_q        <= request.item_value;
				pos_q        <= request.position;
				r_q          <= '0;
				seen_q       <= '0;
				steps_q      <= '0;
				res_status_q <= chte_pkg::ST_OK;
				res_fval_q   <= '0;
				res_bucket_q <= '0;
			end
			chte_pkg::OP_INS_WRITE: begin
				if (full) begin
					res_status_q <= chte_pkg::ST_POOL_FULL;
				end else begin
					res_bucket_q <= b;
				end
			end
			chte_pkg::OP_HEAD_READ: steps_q <= '0;
			chte_pkg::OP_SCAN_HEAD: begin
				prev_q <= NIL;
				if (is_purge) steps_q <= '0;
			end
			chte_pkg::OP_LOAD: cur_q <= head_rd_q;
			chte_pkg::OP_FIND_CHECK: begin
				if (match) begin
					res_bucket_q <= b;
				end else begin
					cur_q   <= link_rd_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			chte_pkg::OP_NOT_FOUND: res_status_q <= chte_pkg::ST_NOT_FOUND;
			chte_pkg::OP_SCAN_NEXT: r_q <= r_q + 1'b1;
			chte_pkg::OP_FETCH_CHECK: begin
				if (fetch_hit) begin
					res_fval_q   <= val_rd_q;
					res_bucket_q <= r_q[BIW-1:0];
				end else begin
					if (!dead_rd_q) seen_q <= seen_q + 1'b1;
					cur_q   <= link_rd_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			chte_pkg::OP_FETCH_MISS: res_status_q <= chte_pkg::ST_RANGE;
			chte_pkg::OP_PURGE_CHECK: begin
				if (!dead_rd_q) prev_q <= cur_q;
				cur_q   <= link_rd_q;
				steps_q <= steps_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (cmd.op == chte_pkg::OP_FINISH) begin
			out_status_q <= res_status_q;
			out_fval_q   <= chte_pkg::FOUND_W'(res_fval_q);
			out_bucket_q <= chte_pkg::BUCKET_W'(res_bucket_q);
			out_live_q   <= chte_pkg::LIVE_W'(live_q);
		end
	end

	// Status to the controller.
	always_comb begin
		st.accept     = request.valid && cmd.in_ready;
		st.clear_last = clr_q == BIW'(NUM_BUCKETS - 1);
		st.div_done   = div_done;
		st.is_insert  = cmd_q == chte_pkg::CMD_INSERT;
		st.is_findrem = cmd_q == chte_pkg::CMD_FIND || is_remove;
		st.is_fetch   = cmd_q == chte_pkg::CMD_FETCH;
		st.is_purge   = is_purge;
		st.cur_end    = cur_q == NIL || steps_q == NIL;
		st.match      = match;
		st.fetch_hit  = fetch_hit;
		st.dead       = dead_rd_q;
		st.prev_nil   = prev_q == NIL;
		st.scan_end   = r_q == BCW'(NUM_BUCKETS);
		st.out_free   = !out_valid_q || response.ready;
	end

	assign request.ready        = cmd.in_ready;
	assign response.valid       = out_valid_q;
	assign response.status      = out_status_q;
	assign response.found_value = out_fval_q;
	assign response.bucket      = out_bucket_q;
	assign response.live_count  = out_live_q;
endmodule

### rtl/chte_ctrl.sv
// ----------------------------------------------------------------------------
// chte_ctrl
// Controller of the hash table engine: sequences the clearing pass, the
// remainder, chain walks and table scans through datapath operations.
// ----------------------------------------------------------------------------
module chte_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  chte_pkg::chte_status_t st,
	output chte_pkg::chte_cmd_t    cmd
);
	chte_pkg::chte_state_t state_q, state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chte_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and datapath operation.
	always_comb begin
		state_nx     = state_q;
		cmd.op       = chte_pkg::OP_NONE;
		cmd.in_ready = 1'b0;
		unique case (state_q)
			chte_pkg::S_CLEAR: begin
				cmd.op = chte_pkg::OP_CLEAR;
				if (st.clear_last) state_nx = chte_pkg::S_IDLE;
			end
			chte_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.accept) begin
					cmd.op   = chte_pkg::OP_CAPTURE;
					state_nx = chte_pkg::S_DIV;
				end
			end
			chte_pkg::S_DIV: begin
				if (st.div_done) begin
					if (st.is_insert) begin
						state_nx = chte_pkg::S_INS_RD;
					end else if (st.is_findrem) begin
						state_nx = chte_pkg::S_FR_HEAD;
					end else if (st.is_fetch || st.is_purge) begin
						state_nx = chte_pkg::S_SC_HEAD;
					end else begin
						state_nx = chte_pkg::S_FIN;
					end
				end
			end
			chte_pkg::S_INS_RD: begin
				cmd.op   = chte_pkg::OP_INS_READ;
				state_nx = chte_pkg::S_INS_WR;
			end
			chte_pkg::S_INS_WR: begin
				cmd.op   = chte_pkg::OP_INS_WRITE;
				state_nx = chte_pkg::S_FIN;
			end
			chte_pkg::S_FR_HEAD: begin
				cmd.op   = chte_pkg::OP_HEAD_READ;
				state_nx = chte_pkg::S_FR_LOAD;
			end
			chte_pkg::S_FR_LOAD: begin
				cmd.op   = chte_pkg::OP_LOAD;
				state_nx = chte_pkg::S_FR_WALK;
			end
			chte_pkg::S_FR_WALK: begin
				if (st.cur_end) begin
					cmd.op   = chte_pkg::OP_NOT_FOUND;
					state_nx = chte_pkg::S_FIN;
				end else begin
					cmd.op   = chte_pkg::OP_NODE_READ;
					state_nx = chte_pkg::S_FR_CHECK;
				end
			end
			chte_pkg::S_FR_CHECK: begin
				cmd.op   = chte_pkg::OP_FIND_CHECK;
				state_nx = st.match ? chte_pkg::S_FIN : chte_pkg::S_FR_WALK;
			end
			chte_pkg::S_SC_HEAD: begin
				if (st.scan_end) begin
					if (st.is_fetch) cmd.op = chte_pkg::OP_FETCH_MISS;
					state_nx = chte_pkg::S_FIN;
				end else begin
					cmd.op   = chte_pkg::OP_SCAN_HEAD;
					state_nx = chte_pkg::S_SC_LOAD;
				end
			end
			chte_pkg::S_SC_LOAD: begin
				cmd.op   = chte_pkg::OP_LOAD;
				state_nx = chte_pkg::S_SC_WALK;
			end
			chte_pkg::S_SC_WALK: begin
				if (st.cur_end) begin
					cmd.op   = chte_pkg::OP_SCAN_NEXT;
					state_nx = chte_pkg::S_SC_HEAD;
				end else begin
					cmd.op   = chte_pkg::OP_NODE_READ;
					state_nx = st.is_fetch ? chte_pkg::S_FT_CHECK : chte_pkg::S_PG_CHECK;
				end
			end
			chte_pkg::S_FT_CHECK: begin
				cmd.op   = chte_pkg::OP_FETCH_CHECK;
				state_nx = st.fetch_hit ? chte_pkg::S_FIN : chte_pkg::S_SC_WALK;
			end
			chte_pkg::S_PG_CHECK: begin
				cmd.op   = chte_pkg::OP_PURGE_CHECK;
				state_nx = (st.dead && !st.prev_nil) ? chte_pkg::S_PG_FIX
					: chte_pkg::S_SC_WALK;
			end
			chte_pkg::S_PG_FIX: begin
				cmd.op   = chte_pkg::OP_PURGE_FIX;
				state_nx = chte_pkg::S_SC_WALK;
			end
			chte_pkg::S_FIN: begin
				if (st.out_free) begin
					cmd.op   = chte_pkg::OP_FINISH;
					state_nx = chte_pkg::S_IDLE;
				end
			end
			default: state_nx = chte_pkg::S_CLEAR;
		endcase
	end
endmodule
